### design/eutc_pkg.sv
// eutc_pkg: payload types and fixed constants of the epoch to utc calendar block
// no dependencies; used by epoch_ms_to_utc_calendar
`default_nettype none

package eutc_pkg;

  typedef struct packed {
    logic signed [53:0] time_ms;
    logic               time_invalid;
  } time_in_t;

  typedef struct packed {
    logic               valid_res;
    logic signed [19:0] year_num;
    logic [3:0]         month_idx;
    logic [4:0]         day_of_month;
    logic [2:0]         weekday_idx;
    logic [4:0]         hour_num;
    logic [5:0]         minute_num;
    logic [5:0]         second_num;
    logic [9:0]         milli_num;
  } cal_out_t;

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic [9:0] milli;
  } tod_t;

  // day bias: whole 400-year eras, also a multiple of 7, keeps all day counts positive
  localparam logic [54:0] T_BIAS   = 55'd9012665491200000;
  localparam logic [27:0] Z_SHIFT  = 28'd719468;
  localparam logic [11:0] ERA_BIAS = 12'd714;

  // ms per day is 1024 * D_DAY_HI
  localparam longint unsigned D_DAY_HI = 84375;
  localparam longint unsigned D_MS     = 125;
  localparam longint unsigned D_SIXTY  = 60;
  localparam longint unsigned D_ERA    = 146097;
  localparam longint unsigned D_QUAD   = 1460;
  localparam longint unsigned D_WEEK   = 7;
  localparam longint unsigned D_YEAR   = 365;
  localparam longint unsigned D_MONTH  = 153;

endpackage

`default_nettype wire

### design/eutc_cdiv.sv
// eutc_cdiv: three-stage pipelined divider by a constant with a sideband bus
// reciprocal multiply, back multiply and subtract, one-step correction; no dependencies
`default_nettype none

module eutc_cdiv #(
  parameter int              XW = 32,
  parameter longint unsigned D  = 3,
  parameter int              QW = 31,
  parameter int              RW = 2,
  parameter int              SW = 1
) (
  input  logic          clk,
  input  logic          en,
  input  logic [XW-1:0] x,
  input  logic [SW-1:0] side_in,
  output logic [QW-1:0] q,
  output logic [RW-1:0] r,
  output logic [SW-1:0] side_out
);

  localparam longint unsigned MUL = (64'd1 << XW) / D;
  localparam int MW = $clog2(MUL + 1);
  localparam int PW = XW + MW;
  localparam logic [MW-1:0] MULV = MW'(MUL);
  localparam logic [RW:0]   DV   = (RW+1)'(D);

  logic [XW-1:0] x1;
  logic [PW-1:0] p1;
  logic [SW-1:0] s1;
  logic [QW-1:0] q2;
  logic [RW:0]   rr2;
  logic [SW-1:0] s2;

  logic [PW-1:0] p_next;
  logic [QW-1:0] qe;
  logic [XW-1:0] qd;
  logic [RW:0]   rr_next;

  assign p_next  = PW'(x) * PW'(MULV);
  assign qe      = QW'(p1[PW-1:XW]);
  assign qd      = XW'(qe) * XW'(D);
  assign rr_next = (RW+1)'(x1 - qd);

  always_ff @(posedge clk) begin
    if (en) begin
      x1  <= x;
      p1  <= p_next;
      s1  <= side_in;
      q2  <= qe;
      rr2 <= rr_next;
      s2  <= s1;
      side_out <= s2;
      if (rr2 >= DV) begin
        q <= q2 + QW'(1);
        r <= RW'(rr2 - DV);
      end else begin
        q <= q2;
        r <= RW'(rr2);
      end
    end
  end

endmodule

`default_nettype wire

### design/epoch_ms_to_utc_calendar.sv
// Breaks a signed millisecond timestamp into the utc gregorian date and time of day.
// A transfer on the time channel reaches the calendar channel through a 24-register
// pipeline, and one timestamp is taken every cycle unless the pipeline holds: it is
// built from three-stage constant dividers (a two-part day split, then ms, seconds,
// minutes in one branch; era, four-year count, weekday, year, month in the other). The
// whole pipeline holds while a result waits on cal_ready, so nothing is lost or repeated.
// An invalid timestamp comes out with valid_res low and every other field zero.
// Uses eutc_pkg and eutc_cdiv.
`default_nettype none

module epoch_ms_to_utc_calendar (
  input  logic               clk,
  input  logic               rst,
  input  logic               time_valid,
  output logic               time_ready,
  input  eutc_pkg::time_in_t time_item,
  output logic               cal_valid,
  input  logic               cal_ready,
  output eutc_pkg::cal_out_t cal_item
);

  localparam int NST = 24;

  logic           adv;
  logic [NST-1:0] vld;

  assign adv        = !vld[NST-1] || cal_ready;
  assign time_ready = adv;
  assign cal_valid  = vld[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NST-2:0], time_valid};
    end
  end

  // input register and bias
  eutc_pkg::time_in_t s1;
  logic [54:0]        u2;
  logic               inv2;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1   <= time_item;
      u2   <= {s1.time_ms[53], s1.time_ms} + eutc_pkg::T_BIAS;
      inv2 <= s1.time_invalid;
    end
  end

  // day split: upper part then lower part of (u / 1024) / 84375
  logic [13:0] q1;
  logic [16:0] r1;
  logic [25:0] sd1;

  eutc_cdiv #(.XW(30), .D(eutc_pkg::D_DAY_HI), .QW(14), .RW(17), .SW(26)) u_div_dhi (
    .clk(clk), .en(adv), .x(u2[54:25]), .side_in({inv2, u2[24:0]}),
    .q(q1), .r(r1), .side_out(sd1)
  );

  logic [14:0] q2;
  logic [16:0] r2;
  logic [24:0] sd2;

  eutc_cdiv #(.XW(32), .D(eutc_pkg::D_DAY_HI), .QW(15), .RW(17), .SW(25)) u_div_dlo (
    .clk(clk), .en(adv), .x({r1, sd1[24:10]}), .side_in({sd1[25], q1, sd1[9:0]}),
    .q(q2), .r(r2), .side_out(sd2)
  );

  logic [27:0] dp;
  logic [9:0]  lo;

  assign dp = 28'({sd2[23:10], q2});
  assign lo = sd2[9:0];

  // time of day branch
  logic [16:0] sod;
  logic [6:0]  rms;
  logic [2:0]  sdm;

  eutc_cdiv #(.XW(24), .D(eutc_pkg::D_MS), .QW(17), .RW(7), .SW(3)) u_div_ms (
    .clk(clk), .en(adv), .x({r2, lo[9:3]}), .side_in(lo[2:0]),
    .q(sod), .r(rms), .side_out(sdm)
  );

  logic [10:0] mod;
  logic [5:0]  rsec;
  logic [9:0]  sds;

  eutc_cdiv #(.XW(17), .D(eutc_pkg::D_SIXTY), .QW(11), .RW(6), .SW(10)) u_div_sec (
    .clk(clk), .en(adv), .x(sod), .side_in({rms, sdm}),
    .q(mod), .r(rsec), .side_out(sds)
  );

  logic [4:0]  hod;
  logic [5:0]  rmin;
  logic [15:0] sdn;

  eutc_cdiv #(.XW(11), .D(eutc_pkg::D_SIXTY), .QW(5), .RW(6), .SW(16)) u_div_min (
    .clk(clk), .en(adv), .x(mod), .side_in({sds, rsec}),
    .q(hod), .r(rmin), .side_out(sdn)
  );

  eutc_pkg::tod_t tod_dly [6];

  always_ff @(posedge clk) begin
    if (adv) begin
      tod_dly[0] <= '{hour: hod, minute: rmin, second: sdn[5:0], milli: sdn[15:6]};
      for (int i = 1; i < 6; i++) begin
        tod_dly[i] <= tod_dly[i-1];
      end
    end
  end

  // date branch
  logic [27:0] z9;
  logic        inv9;

  always_ff @(posedge clk) begin
    if (adv) begin
      z9   <= dp + eutc_pkg::Z_SHIFT;
      inv9 <= sd2[24];
    end
  end

  logic [10:0] era;
  logic [17:0] doe;
  logic        sde;

  eutc_cdiv #(.XW(28), .D(eutc_pkg::D_ERA), .QW(11), .RW(18), .SW(1)) u_div_era (
    .clk(clk), .en(adv), .x(z9), .side_in(inv9),
    .q(era), .r(doe), .side_out(sde)
  );

  logic [6:0]  qa;
  logic [11:0] sda;

  eutc_cdiv #(.XW(18), .D(eutc_pkg::D_QUAD), .QW(7), .RW(11), .SW(12)) u_div_quad (
    .clk(clk), .en(adv), .x(doe), .side_in({sde, era}),
    .q(qa), .r(), .side_out(sda)
  );

  logic [2:0]  r7;
  logic [17:0] sdw;

  eutc_cdiv #(.XW(18), .D(eutc_pkg::D_WEEK), .QW(16), .RW(3), .SW(18)) u_div_week (
    .clk(clk), .en(adv), .x(doe), .side_in(doe),
    .q(), .r(r7), .side_out(sdw)
  );

  // century corrections of the era day
  logic [2:0]  cent;
  logic        last_day;
  logic [17:0] num16;
  logic [2:0]  wd16;
  logic [17:0] doe16;
  logic [10:0] era16;
  logic        inv16;

  assign cent = 3'(sdw >= 18'd36524) + 3'(sdw >= 18'd73048) + 3'(sdw >= 18'd109572)
              + 3'(sdw >= 18'd146096);
  assign last_day = (sdw == 18'd146096);

  always_ff @(posedge clk) begin
    if (adv) begin
      num16 <= sdw - 18'(qa) + 18'(cent) - 18'(last_day);
      wd16  <= (r7 >= 3'd4) ? r7 - 3'd4 : r7 + 3'd3;
      doe16 <= sdw;
      era16 <= sda[10:0];
      inv16 <= sda[11];
    end
  end

  logic [8:0]  yoe;
  logic [32:0] sdy;

  eutc_cdiv #(.XW(18), .D(eutc_pkg::D_YEAR), .QW(9), .RW(9), .SW(33)) u_div_year (
    .clk(clk), .en(adv), .x(num16), .side_in({inv16, era16, wd16, doe16}),
    .q(yoe), .r(), .side_out(sdy)
  );

  logic [1:0]  y100;
  logic [8:0]  doy20;
  logic [8:0]  yoe20;
  logic [10:0] era20;
  logic [2:0]  wd20;
  logic        inv20;

  assign y100 = 2'(yoe >= 9'd100) + 2'(yoe >= 9'd200) + 2'(yoe >= 9'd300);

  always_ff @(posedge clk) begin
    if (adv) begin
      doy20 <= 9'(sdy[17:0] - 18'(yoe) * 18'd365 - 18'(yoe[8:2]) + 18'(y100));
      yoe20 <= yoe;
      wd20  <= sdy[20:18];
      era20 <= sdy[31:21];
      inv20 <= sdy[32];
    end
  end

  logic [10:0] x153;
  logic [3:0]  mp;
  logic [7:0]  rd;
  logic [23:0] sdd;

  assign x153 = 11'(doy20) * 11'd5 + 11'd2;

  eutc_cdiv #(.XW(11), .D(eutc_pkg::D_MONTH), .QW(4), .RW(8), .SW(24)) u_div_month (
    .clk(clk), .en(adv), .x(x153), .side_in({inv20, wd20, era20, yoe20}),
    .q(mp), .r(rd), .side_out(sdd)
  );

  // final assembly
  logic [15:0]        p205;
  logic [4:0]         day_w;
  logic [3:0]         month_w;
  logic               jan_feb;
  logic signed [11:0] era_s;
  logic signed [19:0] era_w;
  logic signed [19:0] year_w;
  logic               inv_f;
  eutc_pkg::cal_out_t res_next;

  assign p205    = 16'(rd) * 16'd205;
  assign day_w   = 5'(p205[15:10]) + 5'd1;
  assign month_w = (mp < 4'd10) ? mp + 4'd2 : mp - 4'd10;
  assign jan_feb = (month_w <= 4'd1);
  assign era_s   = $signed({1'b0, sdd[19:9]}) - $signed(eutc_pkg::ERA_BIAS);
  assign era_w   = {{8{era_s[11]}}, era_s};
  assign year_w  = era_w * 20'sd400 + $signed({11'b0, sdd[8:0]})
                 + $signed({19'b0, jan_feb});
  assign inv_f   = sdd[23];

  always_comb begin
    if (inv_f) begin
      res_next = '0;
    end else begin
      res_next.valid_res    = 1'b1;
      res_next.year_num     = year_w;
      res_next.month_idx    = month_w;
      res_next.day_of_month = day_w;
      res_next.weekday_idx  = sdd[22:20];
      res_next.hour_num     = tod_dly[5].hour;
      res_next.minute_num   = tod_dly[5].minute;
      res_next.second_num   = tod_dly[5].second;
      res_next.milli_num    = tod_dly[5].milli;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cal_item <= res_next;
    end
  end

endmodule

`default_nettype wire
